// ----- rtl/normalized_group_entropy_core_defines.svh -----
// Assertion macros for the port-level checker of the group entropy core.
// No dependencies; include by bare file name.
`ifndef NORMALIZED_GROUP_ENTROPY_CORE_DEFINES_SVH
`define NORMALIZED_GROUP_ENTROPY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NGE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define NGE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/nge_pkg.sv -----
// Shared constants, widths and request types of the group entropy core.
// No dependencies.
package nge_pkg;

    localparam int ALPHABET_SIZE_D = 256;
    localparam int MAX_GROUPS_D    = 16777215;
    localparam int COUNT_WIDTH_D   = 16;

    localparam int SYM_W    = 8;
    localparam int CFG_W    = 16;
    localparam int TAG_W    = 24;
    localparam int GRP_W    = 24;
    localparam int FILL_W   = 16;
    localparam int DIST_W   = 9;
    localparam int LOG_IN_W = 25;
    localparam int LOG_E_W  = 5;
    localparam int FRAC_W   = 16;
    localparam int LOG_W    = LOG_E_W + FRAC_W;
    localparam int DIV_NW   = 46;
    localparam int DIV_DW   = 24;
    localparam int SUM_W    = 46;
    localparam int SCORE_W  = 17;
    localparam int MEAN_W   = 20;

    localparam logic [MEAN_W-1:0]  MEAN_MAX = 20'd524288;
    localparam logic [SCORE_W-1:0] ONE_Q16  = 17'd65536;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

endpackage

// ----- rtl/nge_log2.sv -----
// Iterative fixed-point log2 (Q.16): normalize one bit a cycle, then 16 squarings.
// Depends on nge_pkg.
module nge_log2 (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  nge_pkg::t_log_req       i_req,
    output logic                    o_done,
    output logic [nge_pkg::LOG_W-1:0] o_result
);
    import nge_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } t_log_st;

    t_log_st             r_st;
    logic [30:0]         r_y;
    logic [LOG_E_W-1:0]  r_e;
    logic [FRAC_W-1:0]   r_frac;
    logic [3:0]          r_step;
    logic                r_done;
    logic [LOG_W-1:0]    r_res;

    logic [61:0]         sq;
    logic [31:0]         y2;
    logic [30:0]         n_y;
    logic [FRAC_W-1:0]   n_frac;

    always_comb begin
        sq = r_y * r_y;
        y2 = sq[61:30];
        if (y2[31]) begin
            n_y    = y2[31:1];
            n_frac = {r_frac[FRAC_W-2:0], 1'b1};
        end else begin
            n_y    = y2[30:0];
            n_frac = {r_frac[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.x == '0) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_y  <= 31'(i_req.x);
                            r_e  <= LOG_E_W'(30);
                            r_st <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_y[30]) begin
                        r_step <= '0;
                        r_frac <= '0;
                        r_st   <= L_SQR;
                    end else begin
                        r_y <= {r_y[29:0], 1'b0};
                        r_e <= r_e - 1'b1;
                    end
                end
                L_SQR: begin
                    r_y    <= n_y;
                    r_frac <= n_frac;
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_res  <= {r_e, n_frac};
                        r_done <= 1'b1;
                        r_st   <= L_IDLE;
                    end
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- rtl/nge_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nge_pkg.
module nge_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nge_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [nge_pkg::DIV_NW-1:0] o_quot
);
    import nge_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;

    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_num[DIV_NW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_num  <= i_req.num;
                    r_den  <= i_req.den;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else begin
                r_num <= {r_num[DIV_NW-2:0], ge};
                r_rem <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ----- rtl/normalized_group_entropy_core.sv -----
// Top level of the group entropy core: bin memory, item sequencer, result register.
// Depends on nge_pkg, nge_log2 and nge_div.
//
// Usage: symbols enter on the input channel (i_in_valid / o_in_ready) with
// group and set end markers. The configuration channel (i_cfg_valid /
// o_cfg_ready, always ready) writes the group length; write it while idle.
// One result per set leaves on the output channel (o_out_valid /
// i_out_ready) after the symbol that carries last_in_set.
// Flow: one item at a time. A symbol that does not close a group passes
// through the serial log2 unit once if its bin was empty, else twice, before
// the next accept; a symbol that lands in a saturated bin skips the log2 unit.
// Closing a group adds one log2 pass and a 46-step divide; closing a set adds
// one more divide and, unless the result is undefined, a log2 pass and a third
// divide. Each bin is read, updated and written back before the next
// symbol enters, so no forwarding is needed.
// Reset: all bins read as empty (per-entry valid bits), group length is 1,
// no result is pending. No clearing pass is run.
// Stall: the result sits in an output register; the next set is taken in
// while it waits, and only a second result waits for the first to leave.
module normalized_group_entropy_core #(
    parameter int ALPHABET_SIZE = nge_pkg::ALPHABET_SIZE_D,
    parameter int MAX_GROUPS    = nge_pkg::MAX_GROUPS_D,
    parameter int COUNT_WIDTH   = nge_pkg::COUNT_WIDTH_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [nge_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [nge_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_last_in_group,
    input  logic                        i_last_in_set,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nge_pkg::SCORE_W-1:0] o_score,
    output logic [nge_pkg::MEAN_W-1:0]  o_mean_entropy,
    output logic [nge_pkg::DIST_W-1:0]  o_max_distinct,
    output logic                        o_undefined
);
    import nge_pkg::*;

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ENT_W = TAG_W + COUNT_WIDTH;
    localparam logic [SYM_W:0] TOP_SYM = (SYM_W + 1)'(ALPHABET_SIZE - 1);
    localparam logic [GRP_W-1:0] GRP_LIMIT = GRP_W'(MAX_GROUPS);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_READ = 12'b000000000010,
        S_LOG1 = 12'b000000000100,
        S_LOG0 = 12'b000000001000,
        S_ACC  = 12'b000000010000,
        S_FILL = 12'b000000100000,
        S_LN   = 12'b000001000000,
        S_DQ   = 12'b000010000000,
        S_DM   = 12'b000100000000,
        S_LM   = 12'b001000000000,
        S_DR   = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    // bin memory: {tag, count}
    logic [ENT_W-1:0]         mem [ALPHABET_SIZE];
    logic [ENT_W-1:0]         r_rd;
    logic [ALPHABET_SIZE-1:0] r_vld;

    t_state                 r_st;
    logic [CFG_W-1:0]       r_glen;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_lg;
    logic                   r_ls;
    logic [COUNT_WIDTH-1:0] r_c;
    logic [COUNT_WIDTH-1:0] r_newc;
    logic [SUM_W-1:0]       r_f1;
    logic [SUM_W-1:0]       r_f0;
    logic [SUM_W-1:0]       r_sum;
    logic [FILL_W-1:0]      r_fill;
    logic [DIST_W-1:0]      r_dist;
    logic [DIST_W-1:0]      r_largest;
    logic [TAG_W-1:0]       r_gn;
    logic [SUM_W-1:0]       r_total;
    logic [GRP_W-1:0]       r_groups;
    logic [LOG_W-1:0]       r_ln;
    logic [MEAN_W-1:0]      r_mean;
    logic [SCORE_W-1:0]     r_score;
    logic                   r_undef;

    logic                   r_ov;
    logic [SCORE_W-1:0]     r_o_score;
    logic [MEAN_W-1:0]      r_o_mean;
    logic [DIST_W-1:0]      r_o_dist;
    logic                   r_o_undef;

    t_log_req               r_log_req;
    t_div_req               r_div_req;
    logic                   log_done;
    logic [LOG_W-1:0]       log_res;
    logic                   div_done;
    logic [DIV_NW-1:0]      div_q;

    logic                   in_acc;
    logic [SYM_W:0]         sym_ext;
    logic [IDX_W-1:0]       in_idx;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] rd_c;
    logic [COUNT_WIDTH:0]   c_plus;
    logic [COUNT_WIDTH+LOG_W:0] prod1;
    logic [COUNT_WIDTH+LOG_W:0] prod0;
    logic [FILL_W:0]        n_fill;
    logic [CFG_W-1:0]       glen_eff;
    logic                   close_grp;
    logic [LOG_W-1:0]       n_h;
    logic [SUM_W-1:0]       n_total;
    logic [GRP_W-1:0]       n_groups;
    logic [DIST_W-1:0]      n_largest;
    logic [TAG_W-1:0]       n_gn;
    logic [MEAN_W-1:0]      n_mean;
    logic                   out_load;

    nge_log2 u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_log_req),
        .o_done   (log_done),
        .o_result (log_res)
    );

    nge_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_st == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        sym_ext  = {1'b0, i_symbol};
        in_idx   = (sym_ext >= TOP_SYM) ? IDX_W'(TOP_SYM) : IDX_W'(sym_ext);
        hit      = r_vld[r_idx] && (r_rd[ENT_W-1:COUNT_WIDTH] == r_gn);
        rd_c     = hit ? r_rd[COUNT_WIDTH-1:0] : '0;
        c_plus   = {1'b0, r_c} + 1'b1;
        prod1    = c_plus * log_res;
        prod0    = r_c * log_res;
        n_fill   = {1'b0, r_fill} + 1'b1;
        glen_eff = (r_glen == '0) ? CFG_W'(1) : r_glen;
        close_grp = r_lg || r_ls || (n_fill >= {1'b0, glen_eff});
        // entropy of the closing group, floored at zero
        n_h = (DIV_NW'(r_ln) > div_q) ? (r_ln - LOG_W'(div_q)) : '0;
        if (r_groups < GRP_LIMIT) begin
            n_total  = r_total + SUM_W'(n_h);
            n_groups = r_groups + 1'b1;
        end else begin
            n_total  = r_total;
            n_groups = r_groups;
        end
        n_largest = (r_dist > r_largest) ? r_dist : r_largest;
        n_gn      = r_gn + 1'b1;
        if (n_gn == '0) begin
            n_gn = TAG_W'(1);
        end
        n_mean   = (div_q > DIV_NW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(div_q);
        out_load = (r_st == S_OUT) && (!r_ov || i_out_ready);
    end

    // bin memory: one read at accept, one write-back per item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= mem[in_idx];
        end
        if (r_st == S_FILL) begin
            mem[r_idx] <= {r_gn, r_newc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glen <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_glen <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_vld     <= '0;
            r_gn      <= TAG_W'(1);
            r_sum     <= '0;
            r_fill    <= '0;
            r_dist    <= '0;
            r_largest <= '0;
            r_total   <= '0;
            r_groups  <= '0;
            r_log_req <= '0;
            r_div_req <= '0;
        end else begin
            r_log_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx <= in_idx;
                        r_lg  <= i_last_in_group;
                        r_ls  <= i_last_in_set;
                        r_st  <= S_READ;
                    end
                end
                S_READ: begin
                    r_c <= rd_c;
                    if (rd_c == '0) begin
                        r_dist <= r_dist + 1'b1;
                    end
                    if (rd_c == {COUNT_WIDTH{1'b1}}) begin
                        // saturated bin: keep count, add nothing
                        r_newc <= rd_c;
                        r_st   <= S_FILL;
                    end else begin
                        r_newc          <= rd_c + 1'b1;
                        r_log_req.start <= 1'b1;
                        r_log_req.x     <= LOG_IN_W'({1'b0, rd_c} + 1'b1);
                        r_st            <= S_LOG1;
                    end
                end
                S_LOG1: begin
                    if (log_done) begin
                        r_f1 <= SUM_W'(prod1);
                        r_f0 <= '0;
                        if (r_c != '0) begin
                            r_log_req.start <= 1'b1;
                            r_log_req.x     <= LOG_IN_W'(r_c);
                            r_st            <= S_LOG0;
                        end else begin
                            r_st <= S_ACC;
                        end
                    end
                end
                S_LOG0: begin
                    if (log_done) begin
                        r_f0 <= SUM_W'(prod0);
                        r_st <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum <= r_sum + r_f1 - r_f0;
                    r_st  <= S_FILL;
                end
                S_FILL: begin
                    r_vld[r_idx] <= 1'b1;
                    r_fill       <= FILL_W'(n_fill);
                    if (close_grp) begin
                        r_log_req.start <= 1'b1;
                        r_log_req.x     <= LOG_IN_W'(n_fill);
                        r_st            <= S_LN;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_LN: begin
                    if (log_done) begin
                        r_ln            <= log_res;
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= DIV_NW'(r_sum);
                        r_div_req.den   <= DIV_DW'(r_fill);
                        r_st            <= S_DQ;
                    end
                end
                S_DQ: begin
                    if (div_done) begin
                        r_total   <= n_total;
                        r_groups  <= n_groups;
                        r_largest <= n_largest;
                        r_dist    <= '0;
                        r_sum     <= '0;
                        r_fill    <= '0;
                        r_gn      <= n_gn;
                        if (n_gn == TAG_W'(1)) begin
                            // tag wrap: every bin reads as empty again
                            r_vld <= '0;
                        end
                        if (r_ls) begin
                            r_div_req.start <= 1'b1;
                            r_div_req.num   <= DIV_NW'(n_total);
                            r_div_req.den   <= DIV_DW'(n_groups);
                            r_st            <= S_DM;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_DM: begin
                    if (div_done) begin
                        r_mean <= n_mean;
                        if (r_largest <= DIST_W'(1)) begin
                            r_undef <= 1'b1;
                            r_score <= '0;
                            r_st    <= S_OUT;
                        end else begin
                            r_undef         <= 1'b0;
                            r_log_req.start <= 1'b1;
                            r_log_req.x     <= LOG_IN_W'(r_largest);
                            r_st            <= S_LM;
                        end
                    end
                end
                S_LM: begin
                    if (log_done) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= DIV_NW'({r_mean, 16'b0});
                        r_div_req.den   <= DIV_DW'(log_res);
                        r_st            <= S_DR;
                    end
                end
                S_DR: begin
                    if (div_done) begin
                        r_score <= (div_q >= DIV_NW'(ONE_Q16)) ? '0
                                   : (ONE_Q16 - SCORE_W'(div_q));
                        r_st    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_total   <= '0;
                        r_groups  <= '0;
                        r_largest <= '0;
                        r_st      <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_score <= r_score;
            r_o_mean  <= r_mean;
            r_o_dist  <= r_largest;
            r_o_undef <= r_undef;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_score        = r_o_score;
    assign o_mean_entropy = r_o_mean;
    assign o_max_distinct = r_o_dist;
    assign o_undefined    = r_o_undef;

endmodule

// ----- rtl/nge_checker.sv -----
// Port-level checks on the result channel of the group entropy core, plus bind.
// Depends on nge_pkg and normalized_group_entropy_core_defines.svh.
`include "normalized_group_entropy_core_defines.svh"

module nge_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [nge_pkg::SCORE_W-1:0] o_score,
    input logic [nge_pkg::MEAN_W-1:0]  o_mean_entropy,
    input logic [nge_pkg::DIST_W-1:0]  o_max_distinct,
    input logic                        o_undefined
);
    import nge_pkg::*;

    `NGE_ASSERT_IMP(a_undef_score, i_clk, i_rst_n, o_out_valid && o_undefined, o_score == '0 && o_max_distinct <= DIST_W'(1))
    `NGE_ASSERT_IMP(a_defined_dist, i_clk, i_rst_n, o_out_valid && !o_undefined, o_max_distinct >= DIST_W'(2))
    `NGE_ASSERT_IMP(a_range, i_clk, i_rst_n, o_out_valid, o_mean_entropy <= MEAN_MAX && o_score <= ONE_Q16)
    `NGE_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_score) && $stable(o_mean_entropy))

endmodule

bind normalized_group_entropy_core nge_checker u_nge_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_score        (o_score),
    .o_mean_entropy (o_mean_entropy),
    .o_max_distinct (o_max_distinct),
    .o_undefined    (o_undefined)
);

// ----- dv/normalized_group_entropy_core_checker.sv -----
// Scoreboard for the group entropy core: watches the config, input and result channels,
// predicts each set's score, mean entropy, distinct count and undefined flag, and compares them.
// Depends on nge_pkg for field widths and limits.
module normalized_group_entropy_core_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [nge_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [nge_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_last_in_group,
    input  logic                        i_last_in_set,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [nge_pkg::SCORE_W-1:0] i_score,
    input  logic [nge_pkg::MEAN_W-1:0]  i_mean_entropy,
    input  logic [nge_pkg::DIST_W-1:0]  i_max_distinct,
    input  logic                        i_undefined,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_set_count
);
    import nge_pkg::*;

    localparam longint unsigned BIN_MAX = (64'd1 << COUNT_WIDTH_D) - 1;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [MEAN_W-1:0]  mean;
        logic [DIST_W-1:0]  max_dist;
        logic               undef;
    } t_set_result;

    t_set_result     set_results_q[$];
    logic [CFG_W-1:0] group_len;
    logic [15:0]     bin_count[256];
    logic [TAG_W-1:0] bin_tag[256];
    logic [GRP_W-1:0] group_num;
    int unsigned     distinct_now, widest_group, group_fill, groups_done;
    longint unsigned clogc_acc, entropy_acc;

    function automatic longint unsigned log2_q16(longint unsigned x);
        longint unsigned e, y, frac;
        e = 0;
        frac = 0;
        if (x == 0) return 0;
        while ((x >> e) > 1) e++;
        y = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                frac |= 1;
                y = y >> 1;
            end
        end
        return (e << 16) | frac;
    endfunction

    task automatic close_group();
        longint unsigned ln, q, h;
        ln = log2_q16(group_fill);
        q = (group_fill != 0) ? clogc_acc / group_fill : 0;
        h = (ln > q) ? ln - q : 0;
        if (groups_done < MAX_GROUPS_D) begin
            entropy_acc += h;
            groups_done++;
        end
        if (distinct_now > widest_group) widest_group = distinct_now;
        distinct_now = 0;
        clogc_acc = 0;
        group_fill = 0;
        group_num = group_num + 1;
        if (group_num == 0) begin
            group_num = 1;
            foreach (bin_tag[k]) bin_tag[k] = 0;
        end
    endtask

    task automatic absorb_symbol(logic [SYM_W-1:0] sym, logic end_grp, logic end_set);
        longint unsigned c, mean, ratio, glen;
        t_set_result r;
        int idx;
        idx = (sym >= ALPHABET_SIZE_D) ? ALPHABET_SIZE_D - 1 : sym;
        glen = (group_len == 0) ? 1 : group_len;
        if (bin_tag[idx] != group_num) begin
            bin_tag[idx] = group_num;
            bin_count[idx] = 0;
        end
        c = bin_count[idx];
        if (c == 0) distinct_now++;
        if (c < BIN_MAX) begin
            clogc_acc += (c + 1) * log2_q16(c + 1) - c * log2_q16(c);
            bin_count[idx] = 16'(c + 1);
        end
        if (group_fill < 32'hFFFF_FFFF) group_fill++;
        if (end_grp || end_set || group_fill >= glen) close_group();
        if (end_set) begin
            mean = (groups_done != 0) ? entropy_acc / groups_done : 0;
            if (mean > MEAN_MAX) mean = MEAN_MAX;
            r.undef = (widest_group <= 1);
            r.score = '0;
            if (!r.undef) begin
                ratio = (mean * ONE_Q16) / log2_q16(widest_group);
                r.score = (ratio >= ONE_Q16) ? '0 : SCORE_W'(ONE_Q16 - ratio);
            end
            r.mean = MEAN_W'(mean);
            r.max_dist = DIST_W'(widest_group);
            set_results_q.push_back(r);
            entropy_acc = 0;
            groups_done = 0;
            widest_group = 0;
        end
    endtask

    task automatic compare_result();
        t_set_result want;
        if (set_results_q.size() == 0) begin
            $display("%0t: result with none expected: score %0d mean %0d dist %0d undef %0b",
                     $time, i_score, i_mean_entropy, i_max_distinct, i_undefined);
            o_fail_count++;
            return;
        end
        want = set_results_q.pop_front();
        if (i_score !== want.score) begin
            $display("%0t: score expected %0d actual %0d", $time, want.score, i_score);
            o_fail_count++;
        end
        if (i_mean_entropy !== want.mean) begin
            $display("%0t: mean_entropy expected %0d actual %0d",
                     $time, want.mean, i_mean_entropy);
            o_fail_count++;
        end
        if (i_max_distinct !== want.max_dist) begin
            $display("%0t: max_distinct expected %0d actual %0d",
                     $time, want.max_dist, i_max_distinct);
            o_fail_count++;
        end
        if (i_undefined !== want.undef) begin
            $display("%0t: undefined expected %0b actual %0b", $time, want.undef, i_undefined);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_set_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            group_len = 1;
            foreach (bin_count[k]) begin
                bin_count[k] = 0;
                bin_tag[k] = 0;
            end
            group_num = 1;
            distinct_now = 0;
            widest_group = 0;
            group_fill = 0;
            groups_done = 0;
            clogc_acc = 0;
            entropy_acc = 0;
            set_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result();
                o_set_count++;
            end
            if (i_cfg_valid && i_cfg_ready) group_len = i_cfg_data;
            if (i_in_valid && i_in_ready) absorb_symbol(i_symbol, i_last_in_group, i_last_in_set);
        end
        o_pending = set_results_q.size();
    end
endmodule

// ----- dv/normalized_group_entropy_core_test.sv -----
// Stimulus and verdict for the group entropy core: directed sets, then random sets
// over several group lengths with random gaps and output stalls.
// Depends on nge_pkg, normalized_group_entropy_core and its checker.
module normalized_group_entropy_core_test;
    import nge_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic [SYM_W-1:0] symbol = '0;
    logic last_in_group = 1'b0;
    logic last_in_set = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_ready, in_ready, out_valid, undefined;
    logic [SCORE_W-1:0] score;
    logic [MEAN_W-1:0] mean_entropy;
    logic [DIST_W-1:0] max_distinct;
    int fail_count, pending, set_count;
    int idle_cycles = 0;
    int item_count = 0;
    bit no_gaps = 0;
    int stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    normalized_group_entropy_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_symbol(symbol),
        .i_last_in_group(last_in_group), .i_last_in_set(last_in_set),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_score(score),
        .o_mean_entropy(mean_entropy), .o_max_distinct(max_distinct),
        .o_undefined(undefined)
    );

    normalized_group_entropy_core_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_symbol(symbol),
        .i_last_in_group(last_in_group), .i_last_in_set(last_in_set),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_score(score),
        .i_mean_entropy(mean_entropy), .i_max_distinct(max_distinct),
        .i_undefined(undefined), .o_fail_count(fail_count), .o_pending(pending),
        .o_set_count(set_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Result-side stalls, same short/long mix as the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_symbol(logic [SYM_W-1:0] sym, logic end_grp, logic end_set);
        int gap;
        in_valid <= 1'b1;
        symbol <= sym;
        last_in_group <= end_grp;
        last_in_set <= end_set;
        do @(posedge i_clk); while (!in_ready);
        item_count++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold until every set result is out and the last symbol has settled.
    task automatic drain();
        if (in_valid) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_group_len(logic [CFG_W-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random sets: symbols from a narrow or wide alphabet, random early markers.
    task automatic random_sets(int n_items);
        int alph, in_set;
        logic [SYM_W-1:0] base;
        logic eg, es;
        in_set = 0;
        alph = 4;
        base = '0;
        for (int i = 0; i < n_items; i++) begin
            if (in_set == 0) begin
                case ($urandom_range(0, 4))
                    0: alph = 1;
                    1: alph = 2;
                    2: alph = 5;
                    3: alph = 16;
                    default: alph = 256;
                endcase
                base = SYM_W'($urandom);
                no_gaps = ($urandom_range(0, 5) == 0);
            end
            eg = ($urandom_range(0, 7) == 0);
            es = (i == n_items - 1) || ($urandom_range(0, 24) == 0) || (in_set > 60);
            send_symbol(SYM_W'(base + $urandom_range(0, alph - 1)), eg, es);
            in_set = es ? 0 : in_set + 1;
        end
        no_gaps = 0;
    endtask

    initial begin
        logic [CFG_W-1:0] lens[8];
        lens = '{16'd4, 16'd65535, 16'd0, 16'd3, 16'd1, 16'd16, 16'd7, 16'd65535};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length of one: every symbol is its own group; sets of one and two symbols.
        send_symbol(8'd0, 1'b0, 1'b1);
        send_symbol(8'd255, 1'b0, 1'b0);
        send_symbol(8'd255, 1'b1, 1'b1);
        // Zero length acts as one.
        write_group_len(16'd0);
        send_symbol(8'd170, 1'b0, 1'b0);
        send_symbol(8'd85, 1'b0, 1'b1);
        // Full length with early markers, repeats and extreme symbols.
        write_group_len(16'd65535);
        send_symbol(8'd0, 1'b0, 1'b0);
        send_symbol(8'd255, 1'b0, 1'b0);
        send_symbol(8'd0, 1'b0, 1'b0);
        send_symbol(8'd7, 1'b1, 1'b0);
        send_symbol(8'd3, 1'b0, 1'b0);
        send_symbol(8'd3, 1'b0, 1'b1);
        // Length two: groups close on their own.
        write_group_len(16'd2);
        for (int k = 0; k < 6; k++) send_symbol(k[7:0] * 8'd51, 1'b0, k == 5);

        // One group with every symbol value.
        write_group_len(16'd65535);
        for (int k = 0; k < 256; k++) send_symbol(k[7:0], 1'b0, k == 255);

        foreach (lens[p]) begin
            write_group_len(lens[p]);
            random_sets(85);
        end
        write_group_len(CFG_W'($urandom_range(2, 40)));
        random_sets(110);

        drain();
        $display("Covered %0d symbols over %0d sets across group lengths 0, 1, 2..40, 65535",
                 item_count, set_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- normalized_group_entropy_core.f -----
+incdir+rtl
rtl/nge_pkg.sv
rtl/nge_log2.sv
rtl/nge_div.sv
rtl/normalized_group_entropy_core.sv
rtl/nge_checker.sv
dv/normalized_group_entropy_core_checker.sv
dv/normalized_group_entropy_core_test.sv
